>>> design/assert_macros.svh
// Assertion macros used by the checker file of the design.
// No dependencies; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/bisr_pkg.sv
// Package for the bounded identifier set: sizes, operation and status codes,
// and the control struct passed to each storage cell. No dependencies.
package bisr_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_W     = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_QUERY    = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic shift_en;
        logic active;
    } cell_ctrl_t;

endpackage

>>> design/bisr_cell.sv
// One storage cell of the identifier chain: holds one identifier, hands it
// to the next cell on an append and drives its own match line. Uses bisr_pkg.
module bisr_cell
    import bisr_pkg::*;
(
    input  logic            clk,
    input  cell_ctrl_t      ctrl,
    input  logic [ID_W-1:0] id_in,
    input  logic [ID_W-1:0] cmp_id,
    output logic [ID_W-1:0] id_out,
    output logic            hit
);

    logic [ID_W-1:0] id_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            id_reg <= id_in;
        end
    end

    assign id_out = id_reg;
    assign hit    = ctrl.active && (id_reg == cmp_id);

endmodule

>>> design/bounded_id_set_register.sv
// Channel   | Handshake            | Payload
// input     | in_valid / in_stall  | operation, resource_id
// result    | out_valid / out_stall| status, owned
// config    | cfg_valid / cfg_ready| cfg_data (session_ready)
//
// One transfer is accepted per cycle while in_stall is low; its result is
// registered for the next cycle. Cell chain match lines compare all at once.
// Reset clears the fill count, the ready register and the result valid flag.
// A stalled result holds the input off only while the result register is full.
// Top level of the bounded identifier set; uses bisr_pkg and bisr_cell.
module bounded_id_set_register
    import bisr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            operation,
    input  logic [ID_W-1:0] resource_id,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      status,
    output logic            owned,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);

    logic              ready_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              owned_reg;
    logic              owned_next;
    logic              accept;
    logic              append;
    logic              any_hit;
    logic              full;
    logic [CAPACITY-1:0] hit_vec;
    logic [ID_W-1:0]   chain [CAPACITY+1];
    cell_ctrl_t        ctrl  [CAPACITY];

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign any_hit   = |hit_vec;
    assign full      = (fill_count_reg == CNT_W'(CAPACITY));
    assign chain[0]  = resource_id;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign ctrl[i].shift_en = append;
        assign ctrl[i].active   = (fill_count_reg > CNT_W'(i));

        bisr_cell u_cell (
            .clk    (clk),
            .ctrl   (ctrl[i]),
            .id_in  (chain[i]),
            .cmp_id (resource_id),
            .id_out (chain[i+1]),
            .hit    (hit_vec[i])
        );
    end

    always_comb
    begin
        status_next     = ST_OK;
        owned_next      = 1'b0;
        append          = 1'b0;
        fill_count_next = fill_count_reg;
        if (operation == OP_REGISTER)
        begin
            if (!ready_reg)
            begin
                status_next = ST_FULL;
            end
            else if (any_hit)
            begin
                status_next = ST_PRESENT;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                append          = accept;
                fill_count_next = fill_count_reg + CNT_W'(1);
            end
        end
        else
        begin
            owned_next = ready_reg && any_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg      <= 1'b0;
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ready_reg <= cfg_data;
            end
            if (append)
            begin
                fill_count_reg <= fill_count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            owned_reg  <= owned_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign owned     = owned_reg;

endmodule

>>> design/bisr_checker.sv
// Port-level checker for bounded_id_set_register and its bind statement.
// Uses bisr_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module bisr_checker
    import bisr_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input logic            operation,
    input logic [ID_W-1:0] resource_id,
    input logic            out_valid,
    input logic            out_stall,
    input logic [1:0]      status,
    input logic            owned,
    input logic            cfg_valid,
    input logic            cfg_ready,
    input logic            cfg_data
);

    `ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(owned))
    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && !in_stall, out_valid)
    `ASSERT_NEXT(a_register_not_owned, clk, rst_n, in_valid && !in_stall && operation == OP_REGISTER, !owned)
    `ASSERT_IMPLIES(a_owned_status_ok, clk, rst_n, out_valid && owned, status == ST_OK)

endmodule

bind bounded_id_set_register bisr_checker u_bisr_checker (.*);
